/* src/gf14_pkg.sv */
// Shared constants for the GF(2^m) multiply / power / trace unit.
// Used by every module in src; no dependencies.
package gf14_pkg;

	localparam int FIELD_DEGREE_DEF = 14;
	localparam int EXP_W            = 32;
	localparam int FUNC_W           = 2;

	localparam logic [31:0] MODULUS_RESET = 32'h0000_4021;

	localparam logic [FUNC_W-1:0] FUNC_MUL   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POW   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TRACE = 2'd2;

endpackage

/* src/gf14_redtab.sv */
// Reduction table: rows hold x^(m+i) mod p for i = 0 .. m-2.
// Rebuilt by a sweep after reset and after each modulus write. Uses gf14_pkg.
module gf14_redtab #(
	parameter int FIELD_DEGREE = gf14_pkg::FIELD_DEGREE_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [FIELD_DEGREE:0]                     cfg_data,
	output logic [FIELD_DEGREE-2:0][FIELD_DEGREE-1:0] tab_rows,
	output logic                                      busy
);
	import gf14_pkg::*;

	localparam int D     = FIELD_DEGREE;
	localparam int CNT_W = $clog2(D);

	logic [D-1:0]            poly_q;
	logic [D-1:0]            cur_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [D-2:0][D-1:0]     rows_q;
	logic [D-1:0]            cur_next;

	assign cur_next = {cur_q[D-2:0], 1'b0} ^ (cur_q[D-1] ? poly_q : '0);
	assign busy     = (cnt_q != '0);
	assign tab_rows = rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= MODULUS_RESET[D-1:0];
			cur_q  <= MODULUS_RESET[D-1:0];
			cnt_q  <= CNT_W'(D - 1);
		end else if (cfg_we) begin
			poly_q <= cfg_data[D-1:0];
			cur_q  <= cfg_data[D-1:0];
			cnt_q  <= CNT_W'(D - 1);
		end else if (cnt_q != '0) begin
			cur_q <= cur_next;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift rows down so the first computed row lands in row 0
	always_ff @(posedge clk) begin
		if (cnt_q != '0) begin
			for (int j = 0; j < D - 2; j++) begin
				rows_q[j] <= rows_q[j+1];
			end
			rows_q[D-2] <= cur_q;
		end
	end

endmodule

/* src/gf14_mul.sv */
// Shared combinational GF(2^m) multiplier: carryless product, then table reduction.
// Takes the reduction rows from gf14_redtab. Uses gf14_pkg.
module gf14_mul #(
	parameter int FIELD_DEGREE = gf14_pkg::FIELD_DEGREE_DEF
) (
	input  logic [FIELD_DEGREE-1:0]                   x,
	input  logic [FIELD_DEGREE-1:0]                   y,
	input  logic [FIELD_DEGREE-2:0][FIELD_DEGREE-1:0] tab_rows,
	output logic [FIELD_DEGREE-1:0]                   p
);
	import gf14_pkg::*;

	localparam int D  = FIELD_DEGREE;
	localparam int PW = 2 * D - 1;

	logic [PW-1:0] prod;
	logic [D-1:0]  red;

	always_comb begin
		prod = '0;
		for (int i = 0; i < D; i++) begin
			prod = prod ^ (y[i] ? (PW'(x) << i) : '0);
		end
		red = prod[D-1:0];
		for (int i = 0; i < D - 1; i++) begin
			red = red ^ (prod[D+i] ? tab_rows[i] : '0);
		end
	end

	assign p = red;

endmodule

/* src/gf2_14_mul_pow_trace_unit.sv */
// Top level: sequencer around one shared GF(2^m) multiplier for multiply, power and trace.
// Instantiates gf14_redtab and gf14_mul. Uses gf14_pkg.
//
//  channel  signals                                        direction
//  in       in_valid, in_stall, func, operand_a/b, exponent  item in
//  out      out_valid, out_stall, result, trace_error        result out
//  cfg      cfg_valid, cfg_ready, modulus_poly               register write
//
// Multiply passes through S_MUL, trace repeats S_TRC to sum the repeated squares, and power
// walks the exponent bits up to the highest set one in S_POW, with S_POW_SQ after each set bit.
// Reset and every modulus write start a table sweep; in_stall is high meanwhile.
// The result register frees the sequencer: a new item is taken while a result waits.
// A finished item waits in its last state while out_stall holds the previous result.
module gf2_14_mul_pow_trace_unit #(
	parameter int FIELD_DEGREE = gf14_pkg::FIELD_DEGREE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [FIELD_DEGREE:0]       modulus_poly,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [gf14_pkg::FUNC_W-1:0] func,
	input  logic [FIELD_DEGREE-1:0]     operand_a,
	input  logic [FIELD_DEGREE-1:0]     operand_b,
	input  logic [gf14_pkg::EXP_W-1:0]  exponent,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [FIELD_DEGREE-1:0]     result,
	output logic                        trace_error
);
	import gf14_pkg::*;

	localparam int D     = FIELD_DEGREE;
	localparam int CNT_W = $clog2(D);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_POW,
		S_POW_SQ,
		S_TRC,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [D-1:0]        a_q;
	logic [D-1:0]        b_q;
	logic [D-1:0]        acc_q;
	logic [EXP_W-1:0]    exp_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                trc_q;
	logic                out_valid_q;
	logic [D-1:0]        result_q;
	logic                trace_error_q;

	logic                tab_busy;
	logic [D-2:0][D-1:0] tab_rows;
	logic [D-1:0]        mx;
	logic [D-1:0]        my;
	logic [D-1:0]        mp;
	logic                in_take;
	logic                out_free;

	assign cfg_ready   = 1'b1;
	assign in_stall    = (state_q != S_IDLE) || tab_busy;
	assign in_take     = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign result      = result_q;
	assign trace_error = trace_error_q;

	gf14_redtab #(.FIELD_DEGREE(FIELD_DEGREE)) u_redtab (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (modulus_poly),
		.tab_rows (tab_rows),
		.busy     (tab_busy)
	);

	always_comb begin
		mx = a_q;
		my = a_q;
		case (state_q)
			S_MUL: begin
				mx = a_q;
				my = b_q;
			end
			S_POW: begin
				mx = exp_q[0] ? acc_q : a_q;
				my = a_q;
			end
			default: begin
				mx = a_q;
				my = a_q;
			end
		endcase
	end

	gf14_mul #(.FIELD_DEGREE(FIELD_DEGREE)) u_mul (
		.x        (mx),
		.y        (my),
		.tab_rows (tab_rows),
		.p        (mp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			trc_q         <= 1'b0;
			a_q           <= '0;
			b_q           <= '0;
			acc_q         <= '0;
			exp_q         <= '0;
			cnt_q         <= '0;
			result_q      <= '0;
			trace_error_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						a_q   <= operand_a;
						b_q   <= operand_b;
						exp_q <= exponent;
						cnt_q <= CNT_W'(D - 1);
						trc_q <= (func == FUNC_TRACE);
						case (func)
							FUNC_MUL: begin
								state_q <= S_MUL;
							end
							FUNC_POW: begin
								acc_q   <= D'(1);
								state_q <= S_POW;
							end
							FUNC_TRACE: begin
								acc_q   <= '0;
								state_q <= S_TRC;
							end
							default: begin
								acc_q   <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_MUL: begin
					acc_q   <= mp;
					state_q <= S_DONE;
				end
				S_POW: begin
					if (exp_q == '0) begin
						state_q <= S_DONE;
					end else if (exp_q[0]) begin
						acc_q   <= mp;
						exp_q   <= {1'b0, exp_q[EXP_W-1:1]};
						state_q <= S_POW_SQ;
					end else begin
						a_q   <= mp;
						exp_q <= {1'b0, exp_q[EXP_W-1:1]};
					end
				end
				S_POW_SQ: begin
					a_q     <= mp;
					state_q <= S_POW;
				end
				S_TRC: begin
					acc_q <= acc_q ^ a_q;
					a_q   <= mp;
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						result_q      <= acc_q;
						trace_error_q <= trc_q && (acc_q[D-1:1] != '0);
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		tab_busy |-> in_stall)
		else $error("item accepted during reduction table sweep");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("sequencer ready again right after taking an item");

	a_error_means_wide_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trace_error |-> (result[D-1:1] != '0))
		else $error("trace error flagged on a prime-field sum");
`endif

endmodule

/* bench/gf14_result_checker.sv */
// Checker for gf2_14_mul_pow_trace_unit: tracks the modulus register, predicts every result
// from the accepted operation and compares it with what leaves the output channel.
// Depends on gf14_pkg for field degree, reset modulus and operation codes.
module gf14_result_checker
	import gf14_pkg::*;
#(
	parameter int M = FIELD_DEGREE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [M:0]        modulus_poly,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [M-1:0]      operand_a,
	input  logic [M-1:0]      operand_b,
	input  logic [EXP_W-1:0]  exponent,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [M-1:0]      result,
	input  logic              trace_error,
	output int                mismatches,
	output int                pending,
	output int                checked,
	output int                traces_flagged
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [M-1:0] result;
		logic         trace_error;
	} gf_result_t;

	logic [M:0]  field_modulus;
	gf_result_t  expected_q[$];
	gf_result_t  want;

	function automatic logic [M-1:0] gf_mul(input logic [M-1:0] x, input logic [M-1:0] y);
		logic [2*M-2:0] prod;
		logic [2*M-2:0] poly;
		prod = '0;
		poly = {{(M-2){1'b0}}, 1'b1, field_modulus[M-1:0]};
		for (int i = 0; i < M; i++)
			if (y[i])
				prod ^= {{(M-1){1'b0}}, x} << i;
		for (int i = 2*M-2; i >= M; i--)
			if (prod[i])
				prod ^= poly << (i - M);
		return prod[M-1:0];
	endfunction

	function automatic logic [M-1:0] gf_pow(input logic [M-1:0] base, input logic [EXP_W-1:0] e);
		logic [M-1:0] acc;
		logic [M-1:0] sq;
		acc = M'(1);
		sq = base;
		for (int i = 0; i < EXP_W; i++) begin
			if (e[i])
				acc = gf_mul(acc, sq);
			sq = gf_mul(sq, sq);
		end
		return acc;
	endfunction

	function automatic logic [M-1:0] gf_trace(input logic [M-1:0] x);
		logic [M-1:0] sum;
		logic [M-1:0] c;
		sum = '0;
		c = x;
		for (int j = 0; j < M; j++) begin
			sum ^= c;
			c = gf_mul(c, c);
		end
		return sum;
	endfunction

	function automatic gf_result_t predict_op(input logic [FUNC_W-1:0] f, input logic [M-1:0] a,
			input logic [M-1:0] b, input logic [EXP_W-1:0] e);
		gf_result_t r;
		r = '0;
		case (f)
			FUNC_MUL: r.result = gf_mul(a, b);
			FUNC_POW: r.result = gf_pow(a, e);
			FUNC_TRACE: begin
				r.result = gf_trace(a);
				r.trace_error = (r.result > M'(1));
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned exp_val,
			input int unsigned got_val);
		$display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, exp_val, got_val);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_modulus = MODULUS_RESET[M:0];
			expected_q.delete();
			mismatches = 0;
			checked = 0;
			traces_flagged = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				field_modulus = modulus_poly;
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", 0, 32'(result));
				end else begin
					want = expected_q.pop_front();
					if (result !== want.result)
						report_mismatch("result", 32'(want.result), 32'(result));
					if (trace_error !== want.trace_error)
						report_mismatch("trace_error", 32'(want.trace_error),
							32'(trace_error));
					if (trace_error === 1'b1)
						traces_flagged++;
					checked++;
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_op(func, operand_a, operand_b, exponent));
			pending <= expected_q.size();
		end
	end

endmodule

/* bench/gf2_14_mul_pow_trace_unit_tb.sv */
// Top of the bench for gf2_14_mul_pow_trace_unit: drives operations and modulus writes
// with random gaps and stalls, and gives the verdict from gf14_result_checker.
// Depends on gf14_pkg, the unit under test and bench/gf14_result_checker.sv.
module gf2_14_mul_pow_trace_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gf14_pkg::*;

	localparam int M = FIELD_DEGREE_DEF;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int PHASE_ITEMS = 330;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [M:0]        modulus_poly;
	logic              in_valid;
	logic              in_stall;
	logic [FUNC_W-1:0] func;
	logic [M-1:0]      operand_a;
	logic [M-1:0]      operand_b;
	logic [EXP_W-1:0]  exponent;
	logic              out_valid;
	logic              out_stall;
	logic [M-1:0]      result;
	logic              trace_error;

	int mismatches;
	int pending;
	int checked;
	int traces_flagged;
	int sent_by_func[4];
	int moduli_used;
	int idle_cycles;
	bit tx_idle;
	bit rx_idle;
	bit hold_req;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gf2_14_mul_pow_trace_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.modulus_poly(modulus_poly),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.exponent    (exponent),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result),
		.trace_error (trace_error)
	);

	gf14_result_checker #(.M(M)) u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.modulus_poly  (modulus_poly),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.exponent      (exponent),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result        (result),
		.trace_error   (trace_error),
		.mismatches    (mismatches),
		.pending       (pending),
		.checked       (checked),
		.traces_flagged(traces_flagged)
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results pending",
				idle_cycles, pending);
			$display("gf2_14_mul_pow_trace_unit_tb NOT OK");
			$finish;
		end
	end

	// result side: random stall per transaction while rx_idle is set, one long hold on request
	initial begin
		int wait_n;
		bit hold_done;
		out_stall = 1'b0;
		hold_done = 1'b0;
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				wait_n = LONG_HOLD;
			end else begin
				wait_n = rx_idle ? $urandom_range(0, 16) : 0;
			end
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	function automatic logic [M-1:0] pick_elem();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return M'(1);
			2: return '1;
			default: return M'($urandom());
		endcase
	endfunction

	function automatic logic [EXP_W-1:0] pick_exp();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15);
			1: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	task automatic offer_op(input logic [FUNC_W-1:0] f, input logic [M-1:0] a,
			input logic [M-1:0] b, input logic [EXP_W-1:0] e);
		int gap;
		gap = tx_idle ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		operand_a <= a;
		operand_b <= b;
		exponent <= e;
		do @(posedge clk); while (!(in_valid && !in_stall));
		sent_by_func[f]++;
	endtask

	task automatic random_ops(input int n);
		logic [FUNC_W-1:0] f;
		int r;
		repeat (n) begin
			r = $urandom_range(0, 15);
			if (r < 5)
				f = FUNC_MUL;
			else if (r < 10)
				f = FUNC_POW;
			else if (r < 15)
				f = FUNC_TRACE;
			else
				f = FUNC_UNUSED;
			offer_op(f, pick_elem(), pick_elem(), pick_exp());
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_modulus(input logic [M:0] v);
		cfg_valid <= 1'b1;
		modulus_poly <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		moduli_used++;
	endtask

	initial begin
		logic [M:0] moduli[5];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		modulus_poly = MODULUS_RESET[M:0];
		in_valid = 1'b0;
		func = FUNC_MUL;
		operand_a = '0;
		operand_b = '0;
		exponent = '0;
		moduli_used = 1;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		offer_op(FUNC_MUL, '0, '0, '0);
		offer_op(FUNC_MUL, '1, '1, '1);
		offer_op(FUNC_MUL, M'(1), '1, '0);
		offer_op(FUNC_MUL, '1, M'(1), '0);
		offer_op(FUNC_MUL, 14'h2000, 14'h2000, '0);
		offer_op(FUNC_MUL, 14'h2AAA, 14'h1555, '0);
		offer_op(FUNC_POW, '0, '1, '0);
		offer_op(FUNC_POW, '1, '0, '0);
		offer_op(FUNC_POW, '0, '0, 32'd5);
		offer_op(FUNC_POW, '1, '1, '1);
		offer_op(FUNC_POW, 14'd2, '0, 32'd1);
		offer_op(FUNC_POW, 14'd2, '0, 32'h8000_0000);
		offer_op(FUNC_POW, 14'h1555, 14'h2AAA, 32'hAAAA_AAAA);
		offer_op(FUNC_POW, 14'h2AAA, 14'h1555, 32'h5555_5555);
		offer_op(FUNC_TRACE, '0, '0, '0);
		offer_op(FUNC_TRACE, M'(1), '1, '1);
		offer_op(FUNC_TRACE, '1, '0, '0);
		offer_op(FUNC_TRACE, 14'h2000, '0, '0);
		offer_op(FUNC_UNUSED, '1, '1, '1);
		offer_op(FUNC_UNUSED, '0, '0, '0);
		random_ops(PHASE_ITEMS);
		drain();

		moduli[0] = 15'h4000;
		moduli[1] = 15'h7FFF;
		moduli[2] = 15'h4443;
		moduli[3] = MODULUS_RESET[M:0];
		moduli[4] = 15'($urandom_range(16384, 32767));
		for (int p = 0; p < 5; p++) begin
			tx_idle = (p == 1 || p == 3) ? 1'b0 : (p == 4 ? 1'($urandom()) : 1'b1);
			rx_idle = (p == 0 || p == 3) ? 1'b0 : (p == 4 ? 1'($urandom()) : 1'b1);
			write_modulus(moduli[p]);
			if (p == 1)
				hold_req = 1'b1;
			random_ops(PHASE_ITEMS);
			drain();
		end

		repeat (100) @(posedge clk);
		@(negedge clk);
		$display("covered %0d multiplies, %0d powers, %0d traces, %0d unused selects, %0d moduli",
			sent_by_func[FUNC_MUL], sent_by_func[FUNC_POW], sent_by_func[FUNC_TRACE],
			sent_by_func[FUNC_UNUSED], moduli_used);
		$display("%0d results compared, %0d traces flagged, %0d mismatches, %0d left over",
			checked, traces_flagged, mismatches, pending);
		if (mismatches == 0 && pending == 0)
			$display("gf2_14_mul_pow_trace_unit_tb OK");
		else
			$display("gf2_14_mul_pow_trace_unit_tb NOT OK");
		$finish;
	end

endmodule
